// ===== rtl/ccg_pkg.sv =====
// ----------------------------------------------------------------------------
// ccg_pkg
// Shared types, constants and helper functions for the carrot chasing
// guidance pipeline.
// ----------------------------------------------------------------------------
package ccg_pkg;

    // pipeline geometry
    localparam int CORDIC_STAGES = 16;
    localparam int IDX_W         = 5;
    localparam int CW            = 40;
    localparam int AW            = 20;
    localparam int DIV_STEPS     = 15;

    // angle constants in Q16 radians
    localparam logic signed [AW-1:0] Q16_PI      = 20'sd205887;
    localparam logic signed [AW-1:0] Q16_HALF_PI = 20'sd102944;
    localparam logic signed [AW:0]   Q16_TWO_PI  = 21'sd411775;
    localparam logic [16:0]          CORDIC_GAIN_Q16 = 17'd107922;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_START_X      = 3'd0,
        REG_START_Y      = 3'd1,
        REG_END_X        = 3'd2,
        REG_END_Y        = 3'd3,
        REG_LOOKAHEAD    = 3'd4,
        REG_GAIN         = 3'd5,
        REG_TURN_LIMIT   = 3'd6,
        REG_CRUISE_SPEED = 3'd7
    } cfg_reg_t;

    // vector under rotation plus its companion and the angle accumulator
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] u;
        logic signed [CW-1:0] v;
        logic signed [AW-1:0] ang;
    } cordic_t;

    // fields that ride along the pipeline with each item
    typedef struct packed {
        logic signed [18:0]   yaw;
        logic                 degen;
        logic                 zero;
        logic signed [AW-1:0] theta;
        logic [CW-1:0]        len;
        logic [CW-1:0]        rem;
        logic [DIV_STEPS-1:0] quo;
        logic                 neg;
        logic                 sat;
        logic signed [24:0]   rate;
    } ride_t;

    // atan(2^-i) in Q16 radians
    function automatic logic signed [AW-1:0] atan_q16(input logic [IDX_W-1:0] i);
        logic signed [AW-1:0] a;
        begin
            case (i)
                5'd0:    a = 20'sd51472;
                5'd1:    a = 20'sd30386;
                5'd2:    a = 20'sd16055;
                5'd3:    a = 20'sd8150;
                5'd4:    a = 20'sd4091;
                5'd5:    a = 20'sd2047;
                5'd6:    a = 20'sd1024;
                5'd7:    a = 20'sd512;
                5'd8:    a = 20'sd256;
                5'd9:    a = 20'sd128;
                5'd10:   a = 20'sd64;
                5'd11:   a = 20'sd32;
                5'd12:   a = 20'sd16;
                5'd13:   a = 20'sd8;
                5'd14:   a = 20'sd4;
                5'd15:   a = 20'sd2;
                5'd16:   a = 20'sd1;
                default: a = '0;
            endcase
            return a;
        end
    endfunction

    // quarter turn that brings x into the right half plane
    function automatic cordic_t cordic_pre(input cordic_t c);
        cordic_t o;
        begin
            o = c;
            if (c.x < 0)
            begin
                if (c.y >= 0)
                begin
                    o.x   = c.y;
                    o.y   = -c.x;
                    o.u   = c.v;
                    o.v   = -c.u;
                    o.ang = Q16_HALF_PI;
                end
                else
                begin
                    o.x   = -c.y;
                    o.y   = c.x;
                    o.u   = -c.v;
                    o.v   = c.u;
                    o.ang = -Q16_HALF_PI;
                end
            end
            return o;
        end
    endfunction

endpackage

// ===== rtl/ccg_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// ccg_cordic_cell
// One vectoring micro-rotation, applied to a vector and its companion.
// ----------------------------------------------------------------------------
module ccg_cordic_cell
    import ccg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic [IDX_W-1:0] idx,
    input  logic             in_valid,
    input  cordic_t          in_cs,
    input  ride_t            in_ride,
    output logic             out_valid,
    output cordic_t          out_cs,
    output ride_t            out_ride
);

    logic    valid_reg;
    cordic_t cs_reg;
    cordic_t cs_next;
    ride_t   ride_reg;

    // rotate toward the x axis by the sign of y
    always_comb
    begin
        cs_next = in_cs;
        if (!in_cs.y[CW-1])
        begin
            cs_next.x   = in_cs.x + (in_cs.y >>> idx);
            cs_next.y   = in_cs.y - (in_cs.x >>> idx);
            cs_next.u   = in_cs.u + (in_cs.v >>> idx);
            cs_next.v   = in_cs.v - (in_cs.u >>> idx);
            cs_next.ang = in_cs.ang + atan_q16(idx);
        end
        else
        begin
            cs_next.x   = in_cs.x - (in_cs.y >>> idx);
            cs_next.y   = in_cs.y + (in_cs.x >>> idx);
            cs_next.u   = in_cs.u - (in_cs.v >>> idx);
            cs_next.v   = in_cs.v + (in_cs.u >>> idx);
            cs_next.ang = in_cs.ang - atan_q16(idx);
        end
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cs_reg   <= cs_next;
            ride_reg <= in_ride;
        end
    end

    assign out_valid = valid_reg;
    assign out_cs    = cs_reg;
    assign out_ride  = ride_reg;

endmodule

// ===== rtl/ccg_div_cell.sv =====
// ----------------------------------------------------------------------------
// ccg_div_cell
// One restoring division step for the progress fraction.
// ----------------------------------------------------------------------------
module ccg_div_cell
    import ccg_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  in_valid,
    input  ride_t in_ride,
    output logic  out_valid,
    output ride_t out_ride
);

    logic          valid_reg;
    ride_t         ride_reg;
    ride_t         ride_next;
    logic [CW-1:0] rem2;

    // shift remainder and subtract divisor when it fits
    always_comb
    begin
        ride_next = in_ride;
        rem2      = {in_ride.rem[CW-2:0], 1'b0};
        if (rem2 >= in_ride.len)
        begin
            ride_next.rem = rem2 - in_ride.len;
            ride_next.quo = {in_ride.quo[DIV_STEPS-2:0], 1'b1};
        end
        else
        begin
            ride_next.rem = rem2;
            ride_next.quo = {in_ride.quo[DIV_STEPS-2:0], 1'b0};
        end
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
            ride_reg <= ride_next;
    end

    assign out_valid = valid_reg;
    assign out_ride  = ride_reg;

endmodule

// ===== rtl/carrot_chasing_guidance_unit.sv =====
// ----------------------------------------------------------------------------
// carrot_chasing_guidance_unit
// Carrot chasing path following: pose in, turn rate, speed and progress out.
// ----------------------------------------------------------------------------
// Usage
//   Input channel in_valid/in_ready carries one pose item (pos_x, pos_y,
//   heading). Output channel out_valid/out_ready carries one command item
//   (linear_speed, turn_rate, progress, degenerate) per pose, in order.
//   Configuration port cfg_valid/cfg_ready writes the segment waypoints,
//   lookahead, gain, turn limit and cruise speed; cfg_ready is always high,
//   and writes belong in gaps where no item is in flight.
//   Throughput: one item per cycle while no result is stalled at the output.
//   The path from acceptance to out_valid runs through two chains of CORDIC
//   cells, a 15-cell restoring divider and a few glue stages.
//   The whole pipeline advances together; when out_ready is low and a result
//   is waiting, in_ready drops and every stage holds its contents.
//   Reset clears all valid bits and loads the default segment and gains.
// ----------------------------------------------------------------------------
module carrot_chasing_guidance_unit
    import ccg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [15:0] heading,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [23:0]        linear_speed,
    output logic signed [24:0] turn_rate,
    output logic signed [15:0] progress,
    output logic               degenerate,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    logic [31:0] start_x_reg, start_y_reg, end_x_reg, end_y_reg;
    logic [30:0] lookahead_reg;
    logic [23:0] gain_reg, turn_limit_reg, cruise_speed_reg;

    logic adv;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg      <= 32'd262144;
            start_y_reg      <= 32'd98304;
            end_x_reg        <= 32'hFFFD0000;
            end_y_reg        <= 32'd98304;
            lookahead_reg    <= 31'd65536;
            gain_reg         <= 24'd196608;
            turn_limit_reg   <= 24'd655360;
            cruise_speed_reg <= 24'd98304;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_START_X:      start_x_reg      <= cfg_data;
                REG_START_Y:      start_y_reg      <= cfg_data;
                REG_END_X:        end_x_reg        <= cfg_data;
                REG_END_Y:        end_y_reg        <= cfg_data;
                REG_LOOKAHEAD:    lookahead_reg    <= cfg_data[30:0];
                REG_GAIN:         gain_reg         <= cfg_data[23:0];
                REG_TURN_LIMIT:   turn_limit_reg   <= cfg_data[23:0];
                REG_CRUISE_SPEED: cruise_speed_reg <= cfg_data[23:0];
            endcase
        end
    end

    // global advance: move when the output register is free or being taken
    logic out_valid_reg;
    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    // entry stage: offsets, segment vector, quarter turn
    logic signed [CW-1:0] sx, sy, segx, segy, dx, dy;
    logic                 degen0;
    cordic_t              c0_next;
    ride_t                r0_next;

    always_comb
    begin
        sx     = {{(CW-32){start_x_reg[31]}}, start_x_reg};
        sy     = {{(CW-32){start_y_reg[31]}}, start_y_reg};
        segx   = {{(CW-32){end_x_reg[31]}}, end_x_reg} - sx;
        segy   = {{(CW-32){end_y_reg[31]}}, end_y_reg} - sy;
        dx     = {{(CW-32){pos_x[31]}}, pos_x} - sx;
        dy     = {{(CW-32){pos_y[31]}}, pos_y} - sy;
        degen0 = (segx == '0) && (segy == '0);
        c0_next.x   = degen0 ? CW'(65536) : segx;
        c0_next.y   = degen0 ? '0 : segy;
        c0_next.u   = dx;
        c0_next.v   = dy;
        c0_next.ang = '0;
        c0_next     = cordic_pre(c0_next);
        r0_next       = '0;
        r0_next.yaw   = {heading, 3'b000};
        r0_next.degen = degen0;
    end

    logic    c1_valid [0:CORDIC_STAGES];
    cordic_t c1_cs    [0:CORDIC_STAGES];
    ride_t   c1_ride  [0:CORDIC_STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c1_valid[0] <= 1'b0;
        else if (adv)
            c1_valid[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c1_cs[0]   <= c0_next;
            c1_ride[0] <= r0_next;
        end
    end

    // first chain: segment angle, pose in the segment frame
    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_c1
        ccg_cordic_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .idx       (IDX_W'(i)),
            .in_valid  (c1_valid[i]),
            .in_cs     (c1_cs[i]),
            .in_ride   (c1_ride[i]),
            .out_valid (c1_valid[i+1]),
            .out_cs    (c1_cs[i+1]),
            .out_ride  (c1_ride[i+1])
        );
    end

    // middle stage: carrot vector, progress numerator
    cordic_t              m_cs;
    ride_t                m_ride;
    logic signed [CW-1:0] m_u, m_r, m_cx, m_cy, m_len, m_adiff, m_num, m_diff;
    logic [47:0]          kprod;
    logic [CW-1:0]        ksig;

    assign m_cs   = c1_cs[CORDIC_STAGES];
    assign kprod  = {17'b0, lookahead_reg} * {31'b0, CORDIC_GAIN_Q16};
    assign ksig   = {{(CW-32){1'b0}}, kprod[47:16]};

    always_comb
    begin
        m_ride       = c1_ride[CORDIC_STAGES];
        m_u          = m_cs.u;
        m_r          = m_u[CW-1] ? -m_u : m_u;
        m_cx         = m_r + $signed(ksig) - m_u;
        m_cy         = -m_cs.v;
        m_len        = (m_cs.x > 0) ? m_cs.x : CW'(1);
        m_diff       = m_len - m_r;
        m_adiff      = m_diff[CW-1] ? -m_diff : m_diff;
        m_num        = m_len - m_adiff;
        m_ride.theta = m_cs.ang;
        m_ride.len   = m_len;
        m_ride.neg   = m_num[CW-1];
        m_ride.rem   = m_num[CW-1] ? -m_num : m_num;
        m_ride.sat   = (m_ride.rem >= m_ride.len);
        m_ride.zero  = (m_cx == '0) && (m_cy == '0);
    end

    logic                 s1_valid_reg;
    logic signed [CW-1:0] s1_cx_reg, s1_cy_reg;
    ride_t                s1_ride_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (adv)
            s1_valid_reg <= c1_valid[CORDIC_STAGES];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_cx_reg   <= m_cx;
            s1_cy_reg   <= m_cy;
            s1_ride_reg <= m_ride;
        end
    end

    // quarter turn of the carrot vector
    cordic_t c2_pre_in;
    always_comb
    begin
        c2_pre_in.x   = s1_cx_reg;
        c2_pre_in.y   = s1_cy_reg;
        c2_pre_in.u   = '0;
        c2_pre_in.v   = '0;
        c2_pre_in.ang = '0;
    end

    logic    c2_valid [0:CORDIC_STAGES];
    cordic_t c2_cs    [0:CORDIC_STAGES];
    ride_t   c2_ride  [0:CORDIC_STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c2_valid[0] <= 1'b0;
        else if (adv)
            c2_valid[0] <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c2_cs[0]   <= cordic_pre(c2_pre_in);
            c2_ride[0] <= s1_ride_reg;
        end
    end

    // second chain: bearing of the carrot in the segment frame
    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_c2
        ccg_cordic_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .idx       (IDX_W'(i)),
            .in_valid  (c2_valid[i]),
            .in_cs     (c2_cs[i]),
            .in_ride   (c2_ride[i]),
            .out_valid (c2_valid[i+1]),
            .out_cs    (c2_cs[i+1]),
            .out_ride  (c2_ride[i+1])
        );
    end

    // heading error, wrapped once each way
    ride_t                e_ride;
    logic signed [AW-1:0] e_phi, e_psi;
    logic signed [AW:0]   e_err;

    always_comb
    begin
        e_ride = c2_ride[CORDIC_STAGES];
        e_phi  = e_ride.zero ? '0 : c2_cs[CORDIC_STAGES].ang;
        e_psi  = e_ride.theta + e_phi;
        if (e_psi > Q16_PI)
            e_psi = AW'({e_psi[AW-1], e_psi} - Q16_TWO_PI);
        else if (e_psi <= -Q16_PI)
            e_psi = AW'({e_psi[AW-1], e_psi} + Q16_TWO_PI);
        e_err = {e_psi[AW-1], e_psi} - {{(AW-18){e_ride.yaw[18]}}, e_ride.yaw};
        if (e_err > $signed({e_psi[AW-1] & 1'b0, Q16_PI}))
            e_err = e_err - Q16_TWO_PI;
        else if (e_err < -$signed({1'b0, Q16_PI}))
            e_err = e_err + Q16_TWO_PI;
    end

    logic               s3_valid_reg;
    logic signed [AW:0] s3_err_reg;
    ride_t              s3_ride_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (adv)
            s3_valid_reg <= c2_valid[CORDIC_STAGES];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_err_reg  <= e_err;
            s3_ride_reg <= e_ride;
        end
    end

    // gain product
    localparam int PW = 25 + AW + 1;
    logic                 s4_valid_reg;
    logic signed [PW-1:0] s4_prod_reg;
    ride_t                s4_ride_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_valid_reg <= 1'b0;
        else if (adv)
            s4_valid_reg <= s3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_prod_reg <= $signed({1'b0, gain_reg}) * s3_err_reg;
            s4_ride_reg <= s3_ride_reg;
        end
    end

    // turn rate saturation
    logic signed [PW-1:0] rate_full, lim_pos, lim_neg;
    ride_t                sat_ride;

    always_comb
    begin
        rate_full = s4_prod_reg >>> 16;
        lim_pos   = {{(PW-24){1'b0}}, turn_limit_reg};
        lim_neg   = -lim_pos;
        sat_ride  = s4_ride_reg;
        if (rate_full > lim_pos)
            sat_ride.rate = lim_pos[24:0];
        else if (rate_full < lim_neg)
            sat_ride.rate = lim_neg[24:0];
        else
            sat_ride.rate = rate_full[24:0];
    end

    logic  dv_valid [0:DIV_STEPS];
    ride_t dv_ride  [0:DIV_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_valid[0] <= 1'b0;
        else if (adv)
            dv_valid[0] <= s4_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            dv_ride[0] <= sat_ride;
    end

    // progress divider chain
    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_div
        ccg_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .in_valid  (dv_valid[i]),
            .in_ride   (dv_ride[i]),
            .out_valid (dv_valid[i+1]),
            .out_ride  (dv_ride[i+1])
        );
    end

    // progress sign and saturation
    ride_t              f_ride;
    logic signed [15:0] f_prog;

    always_comb
    begin
        f_ride = dv_ride[DIV_STEPS];
        if (f_ride.degen)
            f_prog = '0;
        else if (f_ride.sat)
            f_prog = f_ride.neg ? 16'sh8000 : 16'sh7FFF;
        else if (f_ride.neg)
            f_prog = -$signed({1'b0, f_ride.quo});
        else
            f_prog = $signed({1'b0, f_ride.quo});
    end

    // output register
    logic signed [24:0] rate_reg;
    logic signed [15:0] prog_reg;
    logic               degen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= dv_valid[DIV_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rate_reg  <= f_ride.rate;
            prog_reg  <= f_prog;
            degen_reg <= f_ride.degen;
        end
    end

    assign out_valid    = out_valid_reg;
    assign linear_speed = cruise_speed_reg;
    assign turn_rate    = rate_reg;
    assign progress     = prog_reg;
    assign degenerate   = degen_reg;

endmodule

// ===== rtl/ccg_checker.sv =====
// ----------------------------------------------------------------------------
// ccg_checker
// Port-level checks on the guidance unit, bound to the top level.
// ----------------------------------------------------------------------------
module ccg_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [23:0]        linear_speed,
    input logic signed [24:0] turn_rate,
    input logic signed [15:0] progress,
    input logic               degenerate
);

    // stalled result item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(turn_rate) && $stable(progress)
                                 && $stable(linear_speed) && $stable(degenerate))
        else $error("result item changed while stalled");

    // input side only stalls when a result item is blocked
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready does not follow output stall");

    // coinciding waypoints give zero progress
    a_degen: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> progress == 16'sd0)
        else $error("degenerate item with nonzero progress");

    // turn rate magnitude stays within the limit field range
    a_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> turn_rate != 25'sh1000000)
        else $error("turn rate outside limit range");

endmodule

bind carrot_chasing_guidance_unit ccg_checker u_ccg_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .linear_speed (linear_speed),
    .turn_rate    (turn_rate),
    .progress     (progress),
    .degenerate   (degenerate)
);

// ===== sim/tb_carrot_chasing_guidance_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_carrot_chasing_guidance_unit
// Drives pose items through the carrot chasing guidance unit under random
// idling on both channels and checks every command item against an in-bench
// fixed point predictor of the segment projection, carrot bearing and progress.
// ----------------------------------------------------------------------------
module tb_carrot_chasing_guidance_unit;
    import ccg_pkg::*;

    localparam int LATENCY   = 2 * CORDIC_STAGES + 22;
    localparam int MAX_CYCLE = 400000;
    localparam int NSTAGE    = 16;

    typedef struct {
        logic [23:0]        speed;
        logic signed [24:0] rate;
        logic signed [15:0] prog;
        logic               degen;
    } command_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] heading;
    logic               out_valid;
    logic               out_ready;
    logic [23:0]        linear_speed;
    logic signed [24:0] turn_rate;
    logic signed [15:0] progress;
    logic               degenerate;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;

    // predictor copy of the registers
    logic signed [31:0] seg_sx, seg_sy, seg_ex, seg_ey;
    logic [30:0]        look_dist;
    logic [23:0]        steer_gain, rate_limit, cruise;

    command_t           pending_cmds[$];
    int                 error_count;
    longint             cycle_count = 0;

    carrot_chasing_guidance_unit dut (.*);

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLE)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic longint atan_entry(input int i);
        longint t[17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                          256, 128, 64, 32, 16, 8, 4, 2, 1};
        return (i < 17) ? t[i] : 0;
    endfunction

    // vectoring rotation of (a,b), companion (c,d) follows, returns angle
    function automatic longint vector_angle(inout longint a, inout longint b,
                                            inout longint c, inout longint d);
        longint ang, t, na, nb, nc, nd;
        ang = 0;
        if (a < 0)
        begin
            if (b >= 0)
            begin
                t = a; a = b; b = -t;
                t = c; c = d; d = -t;
                ang = 102944;
            end
            else
            begin
                t = a; a = -b; b = t;
                t = c; c = -d; d = t;
                ang = -102944;
            end
        end
        for (int i = 0; i < NSTAGE; i++)
        begin
            if (b >= 0)
            begin
                na = a + (b >>> i); nb = b - (a >>> i);
                nc = c + (d >>> i); nd = d - (c >>> i);
                ang += atan_entry(i);
            end
            else
            begin
                na = a - (b >>> i); nb = b + (a >>> i);
                nc = c - (d >>> i); nd = d + (c >>> i);
                ang -= atan_entry(i);
            end
            a = na; b = nb; c = nc; d = nd;
        end
        return ang;
    endfunction

    function automatic command_t predict_command(input logic signed [31:0] px,
                                                 input logic signed [31:0] py,
                                                 input logic signed [15:0] hd);
        command_t cmd;
        longint sgx, sgy, ox, oy, theta, r, ks, cx, cy, zx, zy, phi, psi;
        longint err, rate, lim, prog, len, num;
        bit dg;
        sgx = longint'(seg_ex) - longint'(seg_sx);
        sgy = longint'(seg_ey) - longint'(seg_sy);
        ox = longint'(px) - longint'(seg_sx);
        oy = longint'(py) - longint'(seg_sy);
        dg = (sgx == 0 && sgy == 0);
        if (dg)
        begin
            sgx = 65536;
            sgy = 0;
        end
        theta = vector_angle(sgx, sgy, ox, oy);
        r = (ox < 0) ? -ox : ox;
        ks = (longint'(look_dist) * 107922) >>> 16;
        cx = r + ks - ox;
        cy = -oy;
        zx = 0; zy = 0;
        // carrot sitting on the vehicle gives zero bearing
        if (cx == 0 && cy == 0)
            phi = 0;
        else
            phi = vector_angle(cx, cy, zx, zy);
        psi = theta + phi;
        if (psi > 205887)
            psi -= 411775;
        else if (psi <= -205887)
            psi += 411775;
        err = psi - longint'(hd) * 8;
        if (err > 205887)
            err -= 411775;
        else if (err < -205887)
            err += 411775;
        rate = (longint'(steer_gain) * err) >>> 16;
        lim = longint'(rate_limit);
        if (rate > lim)
            rate = lim;
        else if (rate < -lim)
            rate = -lim;
        if (dg)
            prog = 0;
        else
        begin
            len = (sgx > 0) ? sgx : 1;
            num = len - ((len - r < 0) ? r - len : len - r);
            prog = (num * 32768) / len;
            if (prog > 32767)
                prog = 32767;
            else if (prog < -32768)
                prog = -32768;
        end
        cmd.speed = cruise;
        cmd.rate  = rate[24:0];
        cmd.prog  = prog[15:0];
        cmd.degen = dg;
        return cmd;
    endfunction

    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d",
                 what, got, want, cycle_count);
        error_count++;
    endtask

    // result checker with random stalls on the output side
    initial
    begin
        command_t want;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (pending_cmds.size() == 0)
                    report_mismatch("unexpected item", 1, 0);
                else
                begin
                    want = pending_cmds.pop_front();
                    if (linear_speed !== want.speed)
                        report_mismatch("linear_speed", linear_speed, want.speed);
                    if (turn_rate !== want.rate)
                        report_mismatch("turn_rate", turn_rate, want.rate);
                    if (progress !== want.prog)
                        report_mismatch("progress", progress, want.prog);
                    if (degenerate !== want.degen)
                        report_mismatch("degenerate", degenerate, want.degen);
                end
            end
            if ($urandom_range(0, 3) == 0)
                out_ready <= 1'b0;
            else if ($urandom_range(0, 40) == 0)
                out_ready <= 1'b0;
            else
                out_ready <= 1'b1;
        end
    end

    // valid stays high across back to back writes and drops before the next pose
    task automatic write_register(input cfg_reg_t idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_START_X:      seg_sx     = val;
            REG_START_Y:      seg_sy     = val;
            REG_END_X:        seg_ex     = val;
            REG_END_Y:        seg_ey     = val;
            REG_LOOKAHEAD:    look_dist  = val[30:0];
            REG_GAIN:         steer_gain = val[23:0];
            REG_TURN_LIMIT:   rate_limit = val[23:0];
            REG_CRUISE_SPEED: cruise     = val[23:0];
            default: ;
        endcase
    endtask

    // in_valid stays high across back to back items unless an idle gap is drawn
    task automatic send_pose(input logic [31:0] px, input logic [31:0] py,
                             input logic [15:0] hd, input bit idle);
        int gap;
        cfg_valid <= 1'b0;
        gap = 0;
        if (idle)
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                                              : $urandom_range(0, 2);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        pos_x    <= px;
        pos_y    <= py;
        heading  <= hd;
        pending_cmds.push_back(predict_command(px, py, hd));
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic drain_pipeline();
        in_valid  <= 1'b0;
        cfg_valid <= 1'b0;
        while (pending_cmds.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    function automatic logic [31:0] random_coord();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return 32'(int'($urandom_range(0, 20 << 16)) - (10 << 16));
            default: return 32'(int'($urandom_range(0, 2000 << 16)) - (1000 << 16));
        endcase
    endfunction

    function automatic logic [15:0] random_heading();
        if ($urandom_range(0, 15) == 0)
            return 16'($urandom);
        return 16'(int'($urandom_range(0, 51472)) - 25736);
    endfunction

    // extremes of pose fields, special cases, default configuration
    task automatic test_directed_poses();
        send_pose(32'sh7FFFFFFF, 32'sh7FFFFFFF, 16'sd25736, 1'b0);
        send_pose(32'sh80000000, 32'sh80000000, -16'sd25736, 1'b0);
        send_pose(32'h0, 32'h0, 16'h0, 1'b0);
        send_pose(32'sd262144, 32'sd98304, 16'h0, 1'b0);
        send_pose(-32'sd196608, 32'sd98304, 16'sh7FFF, 1'b0);
        send_pose(32'sd0, 32'sd98304, 16'sh8000, 1'b0);
        send_pose(32'hFFFFFFFF, 32'h0, 16'hFFFF, 1'b0);
        send_pose(32'sd1000000, -32'sd500000, 16'sd12868, 1'b0);
        // pose beyond the end of the segment
        send_pose(-32'sd1000000, 32'sd98304, 16'sd0, 1'b0);
        drain_pipeline();
    endtask

    // coinciding waypoints and carrot landing on the vehicle
    task automatic test_degenerate_segment();
        write_register(REG_START_X, 32'sd65536);
        write_register(REG_START_Y, 32'sd0);
        write_register(REG_END_X, 32'sd65536);
        write_register(REG_END_Y, 32'sd0);
        write_register(REG_LOOKAHEAD, 32'd0);
        send_pose(32'sd65536, 32'sd0, 16'sd0, 1'b0);
        send_pose(32'sd131072, 32'sd0, 16'sd100, 1'b0);
        send_pose(32'sd0, 32'sd65536, -16'sd25736, 1'b1);
        drain_pipeline();
    endtask

    // register extremes
    task automatic test_register_extremes();
        write_register(REG_START_X, 32'sh80000000);
        write_register(REG_START_Y, 32'sh7FFFFFFF);
        write_register(REG_END_X, 32'sh7FFFFFFF);
        write_register(REG_END_Y, 32'sh80000000);
        write_register(REG_LOOKAHEAD, 32'h7FFFFFFF);
        write_register(REG_GAIN, 32'hFFFFFF);
        write_register(REG_TURN_LIMIT, 32'hFFFFFF);
        write_register(REG_CRUISE_SPEED, 32'hFFFFFF);
        repeat (4) send_pose(random_coord(), random_coord(), random_heading(), 1'b1);
        drain_pipeline();
        write_register(REG_GAIN, 32'd0);
        write_register(REG_GAIN, 32'hFFFFFF);
        write_register(REG_TURN_LIMIT, 32'd0);
        write_register(REG_CRUISE_SPEED, 32'd0);
        repeat (4) send_pose(random_coord(), random_coord(), random_heading(), 1'b1);
        drain_pipeline();
    endtask

    // random poses over several random segments
    task automatic test_random_poses();
        for (int phase = 0; phase < 8; phase++)
        begin
            write_register(REG_START_X, random_coord());
            write_register(REG_START_Y, random_coord());
            write_register(REG_END_X, random_coord());
            write_register(REG_END_Y, random_coord());
            write_register(REG_LOOKAHEAD, $urandom_range(0, 3) == 0 ? $urandom
                                          : $urandom_range(0, 10 << 16));
            write_register(REG_GAIN, $urandom_range(0, 3) == 0 ? $urandom
                                     : $urandom_range(0, 8 << 16));
            write_register(REG_TURN_LIMIT, $urandom_range(0, 3) == 0 ? $urandom
                                           : $urandom_range(0, 12 << 16));
            write_register(REG_CRUISE_SPEED, $urandom);
            for (int k = 0; k < 50; k++)
                send_pose(random_coord(), random_coord(), random_heading(),
                          (phase % 3) != 1);
            drain_pipeline();
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        pos_x       = '0;
        pos_y       = '0;
        heading     = '0;
        cfg_valid   = 1'b0;
        cfg_index   = REG_START_X;
        cfg_data    = '0;
        error_count = 0;
        seg_sx      = 32'sd262144;
        seg_sy      = 32'sd98304;
        seg_ex      = -32'sd196608;
        seg_ey      = 32'sd98304;
        look_dist   = 31'd65536;
        steer_gain  = 24'd196608;
        rate_limit  = 24'd655360;
        cruise      = 24'd98304;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_poses();
        test_degenerate_segment();
        test_register_extremes();
        test_random_poses();
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
